>>> hdl/cruise_speed_request_control_assert.svh
// Assertion macros for the checker of the cruise speed request block.
`ifndef CRUISE_SPEED_REQUEST_CONTROL_ASSERT_SVH
`define CRUISE_SPEED_REQUEST_CONTROL_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define CSRC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("csrc assertion failed");

// Checked property, also evaluated during reset.
`define CSRC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("csrc assertion failed");

`endif

>>> hdl/csrc_pkg.sv
package csrc_pkg;

    // Default width of the hold and repeat tick counters
    localparam int CSRC_TICK_BITS = 16;

    // Message queue between the event engine and the output stage
    localparam int CSRC_QDEPTH = 8;
    localparam int CSRC_QAW    = $clog2(CSRC_QDEPTH);
    localparam int CSRC_MAX_MSG = 3;

    // Speed constants
    localparam logic [7:0] SPEED_BRAKE = 8'd255;
    localparam logic [7:0] SPEED_CAP   = 8'd254;

    // Register reset values
    localparam logic [7:0]  RST_SHORT_STEP   = 8'd1;
    localparam logic [7:0]  RST_LONG_STEP    = 8'd5;
    localparam logic [15:0] RST_HOLD_TICKS   = 16'd50;
    localparam logic [15:0] RST_REPEAT_TICKS = 16'd10;

    typedef enum logic [1:0] {
        ACT_BUTTONS = 2'd0,
        ACT_ACTUAL  = 2'd1,
        ACT_OPTIMAL = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_SHORT_STEP   = 2'd0,
        CFG_LONG_STEP    = 2'd1,
        CFG_HOLD_TICKS   = 2'd2,
        CFG_REPEAT_TICKS = 2'd3
    } t_cfg_index;

    typedef enum logic {
        KIND_SPEED     = 1'b0,
        KIND_AUTOPILOT = 1'b1
    } t_kind;

    // One input event
    typedef struct packed {
        t_action    action;
        logic       brake;
        logic       up;
        logic       down;
        logic       autopilot;
        logic [7:0] speed;
    } t_event;

    // One result message
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_msg;

    // All messages of one event
    typedef struct packed {
        logic [1:0]                  count;
        t_msg [CSRC_MAX_MSG-1:0]     msg;
    } t_batch;

endpackage

>>> hdl/csrc_queue.sv
module csrc_queue import csrc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_batch i_batch,
    input  logic   i_pop,
    output t_msg   o_head,
    output logic   o_valid,
    output logic   o_space_ok
);

    t_msg                 r_mem [CSRC_QDEPTH];
    logic [CSRC_QAW-1:0]  r_wr;
    logic [CSRC_QAW-1:0]  r_rd;
    logic [CSRC_QAW:0]    r_cnt;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n     = i_push ? i_batch.count : 2'd0;
    assign pop        = i_pop && (r_cnt != '0);
    assign o_valid    = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    // room for a full batch of messages
    assign o_space_ok = (r_cnt <= (CSRC_QAW+1)'(CSRC_QDEPTH - CSRC_MAX_MSG));

    // storage: up to three consecutive writes per cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < CSRC_MAX_MSG; k++) begin
                if (2'(k) < i_batch.count) begin
                    r_mem[r_wr + CSRC_QAW'(k)] <= i_batch.msg[k];
                end
            end
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + CSRC_QAW'(push_n);
            r_rd  <= r_rd + CSRC_QAW'(pop);
            r_cnt <= r_cnt + (CSRC_QAW+1)'(push_n) - (CSRC_QAW+1)'(pop);
        end
    end

endmodule

>>> hdl/csrc_front.sv
module csrc_front import csrc_pkg::*; #(
    parameter int TICK_COUNT_BITS = CSRC_TICK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_event      i_event,
    input  logic        i_space_ok,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_push,
    output t_batch      o_batch
);

    localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

    logic [7:0]                 r_short_step;
    logic [7:0]                 r_long_step;
    logic [15:0]                r_hold_ticks;
    logic [15:0]                r_repeat_ticks;

    logic [7:0]                 r_req, n_req;
    logic [7:0]                 r_act, n_act;
    logic                       r_ap, n_ap;
    logic [3:0]                 r_prev, n_prev;
    logic [1:0]                 r_sl, n_sl;
    logic [1:0]                 r_hr, n_hr;
    logic [1:0]                 r_ra, n_ra;
    logic [TICK_COUNT_BITS-1:0] r_hc [2];
    logic [TICK_COUNT_BITS-1:0] n_hc [2];
    logic [TICK_COUNT_BITS-1:0] r_rc [2];
    logic [TICK_COUNT_BITS-1:0] n_rc [2];
    logic                       accept;
    logic                       hold_zero;
    logic                       rep_zero;

    // step the request: dir 0 up (capped), dir 1 down (floored)
    function automatic logic [7:0] f_step(input logic dir, input logic [7:0] cur,
                                          input logic [7:0] amt);
        logic [8:0] sum;
        sum = {1'b0, cur} + {1'b0, amt};
        if (!dir) begin
            return (sum < 9'd255) ? sum[7:0] : SPEED_CAP;
        end
        return (amt <= cur) ? (cur - amt) : 8'd0;
    endfunction

    assign accept    = i_valid && i_space_ok;
    assign o_ready   = i_space_ok;
    assign o_push    = accept;
    assign hold_zero = (r_hold_ticks == '0);
    assign rep_zero  = (r_repeat_ticks == '0);

    // event engine: state update and message list of one event
    always_comb begin
        logic [1:0]       n;
        t_msg [2:0]       m;
        logic [1:0]       lvl;
        logic [1:0]       allow;
        logic [1:0]       prv;
        logic [7:0]       amt;

        n_req  = r_req;
        n_act  = r_act;
        n_ap   = r_ap;
        n_prev = r_prev;
        n_sl   = r_sl;
        n_hr   = r_hr;
        n_ra   = r_ra;
        n_hc   = r_hc;
        n_rc   = r_rc;
        n      = 2'd0;
        m      = '0;
        lvl    = {i_event.down, i_event.up};
        allow  = {!i_event.up && !i_event.brake, !i_event.down && !i_event.brake};
        prv    = r_prev[2:1];
        amt    = '0;

        unique case (i_event.action)
            ACT_BUTTONS: begin
                // brake edges
                if (i_event.brake && !r_prev[0]) begin
                    if (n_ap) begin
                        n_ap = 1'b0;
                        if (n != 2'd3) begin
                            m[n].kind = KIND_AUTOPILOT; m[n].value = 8'd0; n = n + 2'd1;
                        end
                    end
                    n_req = SPEED_BRAKE;
                    if (n != 2'd3) begin
                        m[n].kind = KIND_SPEED; m[n].value = n_req; n = n + 2'd1;
                    end
                end else if (!i_event.brake && r_prev[0]) begin
                    n_ra  = 2'b00;
                    n_req = r_act;
                    if (n != 2'd3) begin
                        m[n].kind = KIND_SPEED; m[n].value = n_req; n = n + 2'd1;
                    end
                end
                // up (0) then down (1)
                for (int b = 0; b < 2; b++) begin
                    if (lvl[b] && allow[b]) begin
                        if (!prv[b]) begin
                            if (n_ap) begin
                                n_ap = 1'b0;
                                if (n != 2'd3) begin
                                    m[n].kind = KIND_AUTOPILOT; m[n].value = 8'd0;
                                    n = n + 2'd1;
                                end
                            end
                            if (!n_hr[b]) begin
                                n_hr[b] = 1'b1;
                                n_hc[b] = '0;
                            end
                            amt   = n_sl[b] ? r_long_step : r_short_step;
                            n_req = f_step(1'(b), n_req, amt);
                            if (n != 2'd3) begin
                                m[n].kind = KIND_SPEED; m[n].value = n_req; n = n + 2'd1;
                            end
                        end else if (n_sl[b] && !n_ra[b]) begin
                            n_req = f_step(1'(b), n_req, r_long_step);
                            if (n != 2'd3) begin
                                m[n].kind = KIND_SPEED; m[n].value = n_req; n = n + 2'd1;
                            end
                            n_ra[b] = 1'b1;
                            n_rc[b] = '0;
                        end
                    end else if (!lvl[b] && prv[b]) begin
                        n_ra[b] = 1'b0;
                        n_sl[b] = 1'b0;
                        n_hr[b] = 1'b0;
                    end
                end
                // autopilot toggle on a clean press edge
                if (i_event.autopilot && !i_event.up && !i_event.down && !i_event.brake
                    && !r_prev[3]) begin
                    if (!n_ap) begin
                        n_ap = 1'b1;
                        if (n != 2'd3) begin
                            m[n].kind = KIND_AUTOPILOT; m[n].value = 8'd1; n = n + 2'd1;
                        end
                    end else begin
                        n_ap = 1'b0;
                        if (n != 2'd3) begin
                            m[n].kind = KIND_AUTOPILOT; m[n].value = 8'd0; n = n + 2'd1;
                        end
                        n_req = r_act;
                        if (n != 2'd3) begin
                            m[n].kind = KIND_SPEED; m[n].value = n_req; n = n + 2'd1;
                        end
                    end
                end
                n_prev = {i_event.autopilot, i_event.down, i_event.up, i_event.brake};
            end
            ACT_ACTUAL: begin
                n_act = i_event.speed;
            end
            ACT_OPTIMAL: begin
                if (r_ap) begin
                    n_req = i_event.speed;
                    m[0].kind = KIND_SPEED; m[0].value = n_req; n = 2'd1;
                end
            end
            ACT_TICK: begin
                // hold timers
                for (int b = 0; b < 2; b++) begin
                    if (n_hr[b]) begin
                        if (n_hc[b] != CNT_MAX) begin
                            n_hc[b] = n_hc[b] + 1'b1;
                        end
                        if ((CW'(n_hc[b]) >= CW'(r_hold_ticks)) || hold_zero) begin
                            n_sl[b] = 1'b1;
                            n_hr[b] = 1'b0;
                        end
                    end
                end
                // repeat timers
                for (int b = 0; b < 2; b++) begin
                    if (n_ra[b]) begin
                        if (n_rc[b] != CNT_MAX) begin
                            n_rc[b] = n_rc[b] + 1'b1;
                        end
                        if ((CW'(n_rc[b]) >= CW'(r_repeat_ticks)) || rep_zero) begin
                            n_rc[b] = '0;
                            if (n_sl[b]) begin
                                n_req = f_step(1'(b), n_req, r_long_step);
                                if (n != 2'd3) begin
                                    m[n].kind = KIND_SPEED; m[n].value = n_req;
                                    n = n + 2'd1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (n != 2'd0) begin
            m[n - 2'd1].last = 1'b1;
        end
        o_batch.count = n;
        o_batch.msg   = m;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_step   <= RST_SHORT_STEP;
            r_long_step    <= RST_LONG_STEP;
            r_hold_ticks   <= RST_HOLD_TICKS;
            r_repeat_ticks <= RST_REPEAT_TICKS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SHORT_STEP:   r_short_step   <= i_cfg_data[7:0];
                CFG_LONG_STEP:    r_long_step    <= i_cfg_data[7:0];
                CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data;
                CFG_REPEAT_TICKS: r_repeat_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // controller state, committed per accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req  <= '0;
            r_act  <= '0;
            r_ap   <= 1'b0;
            r_prev <= '0;
            r_sl   <= '0;
            r_hr   <= '0;
            r_ra   <= '0;
            r_hc   <= '{default: '0};
            r_rc   <= '{default: '0};
        end else if (accept) begin
            r_req  <= n_req;
            r_act  <= n_act;
            r_ap   <= n_ap;
            r_prev <= n_prev;
            r_sl   <= n_sl;
            r_hr   <= n_hr;
            r_ra   <= n_ra;
            r_hc   <= n_hc;
            r_rc   <= n_rc;
        end
    end

endmodule

>>> hdl/csrc_back.sv
module csrc_back import csrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_msg       i_head,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic [0:0] o_m_tuser,
    output logic       o_m_tlast
);

    logic r_valid;
    t_msg r_msg;
    logic load;

    assign load       = !r_valid || i_m_tready;
    assign o_pop      = load && i_valid;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_msg.value;
    assign o_m_tuser  = r_msg.kind;
    assign o_m_tlast  = r_msg.last;

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_msg <= i_head;
        end
    end

endmodule

>>> hdl/cruise_speed_request_control.sv
// Channel   Dir  Signals                      Payload
// s (event) in   i_s_tvalid / o_s_tready      tuser: action; tdata: brake, up, down,
//                                             autopilot, speed_value
// m (msg)   out  o_m_tvalid / i_m_tready      tuser: message_kind; tdata: message_value;
//                                             tlast: last
// cfg       in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// An event is accepted and its zero to three messages are queued at once;
// events may follow back to back while the queue has room for three more messages.
// The output register sends one message per cycle while i_m_tready is high; an event
// without any messages sends nothing on the output.
// Reset is synchronous active low and clears the controller state and the queue.
// A stalled output only stops input acceptance once the message queue is near full.
module cruise_speed_request_control import csrc_pkg::*; #(
    parameter int TICK_COUNT_BITS = CSRC_TICK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [0] brake, [1] up, [2] down, [3] autopilot,
                                     // [11:4] speed_value, [15:12] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] message_value
    output logic [0:0]  o_m_tuser,   // [0] message_kind
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_event ev;
    t_batch batch;
    t_msg   head;
    logic   push;
    logic   pop;
    logic   q_valid;
    logic   space_ok;

    // unpack the event request
    always_comb begin
        ev.action    = t_action'(i_s_tuser);
        ev.brake     = i_s_tdata[0];
        ev.up        = i_s_tdata[1];
        ev.down      = i_s_tdata[2];
        ev.autopilot = i_s_tdata[3];
        ev.speed     = i_s_tdata[11:4];
    end

    csrc_front #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_event     (ev),
        .i_space_ok  (space_ok),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_batch     (batch)
    );

    csrc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_batch    (batch),
        .i_pop      (pop),
        .o_head     (head),
        .o_valid    (q_valid),
        .o_space_ok (space_ok)
    );

    csrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

>>> hdl/csrc_checker.sv
`include "cruise_speed_request_control_assert.svh"

module csrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic [0:0]  o_m_tuser,
    input logic        o_m_tlast,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // a stalled message holds
    `CSRC_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser) && $stable(o_m_tlast))

    // autopilot state messages carry only on or off
    `CSRC_ASSERT(a_ap_value, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[7:1] == 7'd0)

    // switching the autopilot on is always the final message of its event
    `CSRC_ASSERT(a_ap_on_last, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser[0] && o_m_tdata[0] |-> o_m_tlast)

    // reset empties the output register
    `CSRC_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind cruise_speed_request_control csrc_checker u_csrc_checker (.*);

>>> sim/cruise_speed_request_control_test.sv
module cruise_speed_request_control_test;
    import csrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int BY_MODEL       = -1;

    // Button level masks, laid out as tdata[3:0]
    localparam logic [3:0] NONE = 4'b0000;
    localparam logic [3:0] BRK  = 4'b0001;
    localparam logic [3:0] UP   = 4'b0010;
    localparam logic [3:0] DN   = 4'b0100;
    localparam logic [3:0] AP   = 4'b1000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    cruise_speed_request_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #2 i_clk = ~i_clk;

    // Controller state as the testbench sees it
    logic [7:0]  short_step_cfg, long_step_cfg;
    logic [15:0] hold_ticks_cfg, repeat_ticks_cfg;
    logic [7:0]  req_speed, act_speed;
    logic        ap_on;
    logic [3:0]  prev_btn;
    logic [1:0]  long_mode, hold_run, rpt_on;
    logic [15:0] hold_cnt [2];
    logic [15:0] rpt_cnt  [2];

    t_msg new_msgs[$];   // messages of the event being predicted
    t_msg due_msgs[$];   // messages still owed by the block

    int   src_idle_pct = 29;
    int   snk_idle_pct = 75;
    int   mismatches   = 0;
    int   msgs_checked = 0;
    int   events_sent  = 0;
    int   quiet_cycles = 0;
    logic [3:0] held_btn = NONE;

    // Directed rows: event plus, where obvious, the messages it gives
    typedef struct {
        t_action    act;
        logic [3:0] btn;
        logic [7:0] spd;
        int         n;
        t_kind      k0;
        logic [7:0] v0;
        t_kind      k1;
        logic [7:0] v1;
    } t_plan_row;

    // Runs with hold and repeat ticks at zero, steps at reset values
    t_plan_row plan [25] = '{
        // actual speed is stored silently
        '{ACT_ACTUAL,  NONE,   8'd255, 0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // optimal speed ignored while autopilot is off
        '{ACT_OPTIMAL, NONE,   8'd200, 0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, AP,     8'd0,   1, KIND_AUTOPILOT, 8'd1, KIND_SPEED, 8'd0},
        '{ACT_OPTIMAL, NONE,   8'd255, 1, KIND_SPEED, 8'd255, KIND_SPEED, 8'd0},
        // brake press drops autopilot and asks for the brake speed
        '{ACT_BUTTONS, BRK,    8'd0,   2, KIND_AUTOPILOT, 8'd0, KIND_SPEED, 8'd255},
        // press under brake is ignored but remembered
        '{ACT_BUTTONS, BRK|UP, 8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, UP,     8'd0,   1, KIND_SPEED, 8'd255, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_ACTUAL,  NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // step up from 255 is capped
        '{ACT_BUTTONS, UP,     8'd0,   1, KIND_SPEED, 8'd254, KIND_SPEED, 8'd0},
        // zero hold ticks: long mode after one tick
        '{ACT_TICK,    NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, UP,     8'd0,   BY_MODEL, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_TICK,    NONE,   8'd0,   BY_MODEL, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, BRK|UP, 8'd0,   1, KIND_SPEED, 8'd255, KIND_SPEED, 8'd0},
        // repeat keeps going while the brake is held
        '{ACT_TICK,    NONE,   8'd0,   BY_MODEL, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, NONE,   8'd0,   1, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // step down from zero floors at zero
        '{ACT_BUTTONS, DN,     8'd0,   1, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // up and down together: neither acts
        '{ACT_BUTTONS, DN|UP,  8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // autopilot button masked by another button
        '{ACT_BUTTONS, AP|UP,  8'd0,   1, KIND_SPEED, 8'd1, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, AP,     8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, AP,     8'd0,   1, KIND_AUTOPILOT, 8'd1, KIND_SPEED, 8'd0},
        '{ACT_BUTTONS, NONE,   8'd0,   0, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0},
        // autopilot off falls back to the actual speed
        '{ACT_BUTTONS, AP,     8'd0,   2, KIND_AUTOPILOT, 8'd0, KIND_SPEED, 8'd0}
    };

    // ---------------- speed request predictor ----------------

    function automatic void post_msg(t_kind k, logic [7:0] v);
        t_msg m;
        m.kind  = k;
        m.value = v;
        m.last  = 1'b0;
        new_msgs.push_back(m);
    endfunction

    function automatic void set_autopilot_state(logic on);
        if (ap_on != on) begin
            ap_on = on;
            post_msg(KIND_AUTOPILOT, {7'd0, on});
        end
    endfunction

    function automatic void ask_speed(logic [7:0] v);
        req_speed = v;
        post_msg(KIND_SPEED, v);
    endfunction

    // down_dir 0 steps up (capped), 1 steps down (floored)
    function automatic void step_request(int down_dir, logic [7:0] amount);
        logic [8:0] total;
        if (down_dir == 0) begin
            total = {1'b0, req_speed} + {1'b0, amount};
            ask_speed(total < 9'd255 ? total[7:0] : SPEED_CAP);
        end else begin
            ask_speed(amount <= req_speed ? req_speed - amount : 8'd0);
        end
    endfunction

    // b: 0 up, 1 down
    function automatic void button_update(int b, logic level, logic allowed, logic was_down);
        if (level && allowed) begin
            if (!was_down) begin
                set_autopilot_state(1'b0);
                if (!hold_run[b]) begin
                    hold_run[b] = 1'b1;
                    hold_cnt[b] = '0;
                end
                step_request(b, long_mode[b] ? long_step_cfg : short_step_cfg);
            end else if (long_mode[b] && !rpt_on[b]) begin
                step_request(b, long_step_cfg);
                rpt_on[b]  = 1'b1;
                rpt_cnt[b] = '0;
            end
        end else if (!level && was_down) begin
            rpt_on[b]    = 1'b0;
            long_mode[b] = 1'b0;
            hold_run[b]  = 1'b0;
        end
    endfunction

    // Hold timers first, then repeat timers; counters saturate
    function automatic void advance_timers();
        int b;
        for (b = 0; b < 2; b++) begin
            if (hold_run[b]) begin
                if (hold_cnt[b] != 16'hFFFF)
                    hold_cnt[b]++;
                if (hold_cnt[b] >= hold_ticks_cfg || hold_ticks_cfg == 16'd0) begin
                    long_mode[b] = 1'b1;
                    hold_run[b]  = 1'b0;
                end
            end
        end
        for (b = 0; b < 2; b++) begin
            if (rpt_on[b]) begin
                if (rpt_cnt[b] != 16'hFFFF)
                    rpt_cnt[b]++;
                if (rpt_cnt[b] >= repeat_ticks_cfg || repeat_ticks_cfg == 16'd0) begin
                    rpt_cnt[b] = '0;
                    if (long_mode[b])
                        step_request(b, long_step_cfg);
                end
            end
        end
    endfunction

    function automatic void predict_event(t_event ev);
        logic [3:0] was;
        was = prev_btn;
        new_msgs.delete();
        case (ev.action)
            ACT_BUTTONS: begin
                if (ev.brake && !was[0]) begin
                    set_autopilot_state(1'b0);
                    ask_speed(SPEED_BRAKE);
                end else if (!ev.brake && was[0]) begin
                    rpt_on = 2'b00;
                    ask_speed(act_speed);
                end
                button_update(0, ev.up, !ev.down && !ev.brake, was[1]);
                button_update(1, ev.down, !ev.up && !ev.brake, was[2]);
                if (ev.autopilot && !ev.up && !ev.down && !ev.brake && !was[3]) begin
                    if (!ap_on) begin
                        set_autopilot_state(1'b1);
                    end else begin
                        set_autopilot_state(1'b0);
                        ask_speed(act_speed);
                    end
                end
                prev_btn = {ev.autopilot, ev.down, ev.up, ev.brake};
            end
            ACT_ACTUAL: act_speed = ev.speed;
            ACT_OPTIMAL: begin
                if (ap_on)
                    ask_speed(ev.speed);
            end
            default: advance_timers();
        endcase
        if (new_msgs.size() > 0)
            new_msgs[new_msgs.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    // Button levels mostly walk one press or release at a time so holds build up
    function automatic t_event random_event();
        t_event ev;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 40)
            ev.action = ACT_TICK;
        else if (pick < 75)
            ev.action = ACT_BUTTONS;
        else if (pick < 85)
            ev.action = ACT_ACTUAL;
        else
            ev.action = ACT_OPTIMAL;
        if ($urandom_range(4) == 0)
            ev.speed = $urandom_range(1) ? 8'd255 : 8'd0;
        else
            ev.speed = 8'($urandom_range(255));
        if (ev.action == ACT_BUTTONS) begin
            if ($urandom_range(9) == 0) begin
                held_btn = 4'($urandom_range(15));
            end else if (held_btn[0] && $urandom_range(2) == 0) begin
                held_btn[0] = 1'b0;
            end else begin
                pick = $urandom_range(99);
                if (pick < 10)
                    held_btn ^= BRK;
                else if (pick < 45)
                    held_btn ^= UP;
                else if (pick < 75)
                    held_btn ^= DN;
                else
                    held_btn ^= AP;
            end
        end
        {ev.autopilot, ev.down, ev.up, ev.brake} = held_btn;
        return ev;
    endfunction

    // Offer one event; on acceptance log what it should produce.
    // Valid is left high so the next event can follow without a gap.
    task automatic send_event(t_event ev, int n, t_kind k0, logic [7:0] v0,
                              t_kind k1, logic [7:0] v1);
        t_msg m;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, ev.speed, ev.autopilot, ev.down, ev.up, ev.brake};
        i_s_tuser  <= ev.action;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        events_sent++;
        predict_event(ev);
        if (n == BY_MODEL) begin
            foreach (new_msgs[i])
                due_msgs.push_back(new_msgs[i]);
        end else begin
            if (n >= 1) begin
                m.kind = k0; m.value = v0; m.last = (n == 1);
                due_msgs.push_back(m);
            end
            if (n >= 2) begin
                m.kind = k1; m.value = v1; m.last = 1'b1;
                due_msgs.push_back(m);
            end
        end
    endtask

    // One register write; the predictor takes the value at the same edge
    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SHORT_STEP:   short_step_cfg   = val[7:0];
            CFG_LONG_STEP:    long_step_cfg    = val[7:0];
            CFG_HOLD_TICKS:   hold_ticks_cfg   = val;
            CFG_REPEAT_TICKS: repeat_ticks_cfg = val;
        endcase
    endtask

    task automatic apply_settings(logic [7:0] s, logic [7:0] l, logic [15:0] h,
                                  logic [15:0] r);
        write_reg(CFG_SHORT_STEP, {8'd0, s});
        write_reg(CFG_LONG_STEP, {8'd0, l});
        write_reg(CFG_HOLD_TICKS, h);
        write_reg(CFG_REPEAT_TICKS, r);
        i_cfg_we <= 1'b0;
    endtask

    // Let every owed message out, then give silent events time to finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (due_msgs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_run(int count);
        repeat (count)
            send_event(random_event(), BY_MODEL, KIND_SPEED, 8'd0, KIND_SPEED, 8'd0);
    endtask

    // ---------------- message checker and receiver stalls ----------------

    always @(posedge i_clk) begin : msg_check
        t_msg want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            msgs_checked++;
            if (due_msgs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected message kind=%0d value=%0d last=%0d",
                         $time, o_m_tuser[0], o_m_tdata, o_m_tlast);
            end else begin
                want = due_msgs.pop_front();
                if (o_m_tuser[0] != want.kind || o_m_tdata != want.value ||
                    o_m_tlast != want.last) begin
                    mismatches++;
                    $display("%0t: expected kind=%0d value=%0d last=%0d",
                             $time, want.kind, want.value, want.last);
                    $display("%0t:      got kind=%0d value=%0d last=%0d",
                             $time, o_m_tuser[0], o_m_tdata, o_m_tlast);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d messages still owed",
                     $time, WATCHDOG_LIMIT, due_msgs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_event ev;
        int     directed_count;

        short_step_cfg   = RST_SHORT_STEP;
        long_step_cfg    = RST_LONG_STEP;
        hold_ticks_cfg   = RST_HOLD_TICKS;
        repeat_ticks_cfg = RST_REPEAT_TICKS;
        req_speed = '0;
        act_speed = '0;
        ap_on     = 1'b0;
        prev_btn  = '0;
        long_mode = '0;
        hold_run  = '0;
        rpt_on    = '0;
        hold_cnt  = '{16'd0, 16'd0};
        rpt_cnt   = '{16'd0, 16'd0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero tick registers act as one tick
        write_reg(CFG_HOLD_TICKS, 16'd0);
        write_reg(CFG_REPEAT_TICKS, 16'd0);
        i_cfg_we <= 1'b0;
        foreach (plan[i]) begin
            ev.action = plan[i].act;
            {ev.autopilot, ev.down, ev.up, ev.brake} = plan[i].btn;
            ev.speed = plan[i].spd;
            send_event(ev, plan[i].n, plan[i].k0, plan[i].v0, plan[i].k1, plan[i].v1);
        end
        directed_count = events_sent;
        settle();

        // Largest steps, shortest timers
        apply_settings(8'd255, 8'd255, 16'd1, 16'd1);
        random_run(100);
        settle();

        // Zero steps, longest timers; stall roles swapped
        src_idle_pct = 75;
        snk_idle_pct = 29;
        apply_settings(8'd0, 8'd0, 16'd65535, 16'd65535);
        random_run(100);
        settle();

        // Mid-range settings at full rate
        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_settings(8'd3, 8'd7, 16'd3, 16'd2);
        random_run(55);
        settle();

        $display("Ran %0d events (%0d directed)", events_sent, directed_count);
        $display("over four register settings and three stall mixes");
        $display("Checked %0d messages: %0d mismatches, %0d left owed",
                 msgs_checked, mismatches, due_msgs.size());
        if (mismatches == 0 && due_msgs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
